[hw/rtl/nom_pkg.sv]
// Package for the needle overlap merge block: item types, queue sizing, command entry.
package nom_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [31:0] query_begin;
        logic [31:0] query_finish;
        logic [31:0] target_begin;
        logic [31:0] target_finish;
        logic        list_end;
    } t_in_item;

    typedef struct packed {
        logic [31:0] out_query_begin;
        logic [31:0] out_query_finish;
        logic [31:0] out_target_begin;
        logic [31:0] out_target_finish;
        logic        out_final;
    } t_out_item;

    // One queue entry: one or two result items caused by one input item.
    typedef struct packed {
        logic      two;
        t_out_item res0;
        t_out_item res1;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[hw/rtl/nom_front.sv]
// Front end: takes input items, classifies them against the pending block, queues results.
module nom_front import nom_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_stall,
    input  t_q_status i_qstat,
    output logic      o_push,
    output t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        K_LOAD  = 5'b00001,
        K_DROP  = 5'b00010,
        K_TRIM  = 5'b00100,
        K_MERGE = 5'b01000,
        K_SPLIT = 5'b10000
    } t_kind;

    logic        r_pv;
    logic [31:0] r_pqb, r_pqf, r_ptb, r_ptf;
    logic        n_pv;
    logic [31:0] n_pqb, n_pqf, n_ptb, n_ptf;

    t_kind kind;
    logic  accept;
    logic  overlap;
    logic  emit_old;
    logic [31:0] trim_tb;

    assign o_stall = i_qstat.full;
    assign accept  = i_valid && !i_qstat.full;
    assign overlap = r_pqf > i_item.query_begin;
    assign trim_tb = i_item.target_begin + r_pqf - i_item.query_begin;

    always_comb begin
        if (!r_pv) begin
            kind = K_LOAD;
        end else if (overlap) begin
            if (r_pqb <= i_item.query_begin && r_pqf >= i_item.query_finish) begin
                kind = K_DROP;
            end else begin
                kind = K_TRIM;
            end
        end else if (r_pqf == i_item.query_begin && r_ptf == i_item.target_begin) begin
            kind = K_MERGE;
        end else begin
            kind = K_SPLIT;
        end
    end

    // Pending block after this item's case, before any end-of-list flush.
    always_comb begin
        n_pqb = i_item.query_begin;
        n_pqf = i_item.query_finish;
        n_ptb = i_item.target_begin;
        n_ptf = i_item.target_finish;
        case (kind)
            K_LOAD, K_SPLIT: begin
            end
            K_DROP: begin
                n_pqb = r_pqb;
                n_pqf = r_pqf;
                n_ptb = r_ptb;
                n_ptf = r_ptf;
            end
            K_TRIM: begin
                n_pqb = r_pqf;
                n_ptb = trim_tb;
            end
            K_MERGE: begin
                n_pqb = r_pqb;
                n_ptb = r_ptb;
            end
            default: begin
            end
        endcase
        n_pv = !i_item.list_end;
    end

    assign emit_old = (kind == K_TRIM) || (kind == K_SPLIT);

    always_comb begin
        o_cmd = '0;
        if (emit_old) begin
            o_cmd.two  = i_item.list_end;
            o_cmd.res0 = '{r_pqb, r_pqf, r_ptb, r_ptf, 1'b0};
            o_cmd.res1 = '{n_pqb, n_pqf, n_ptb, n_ptf, 1'b1};
        end else begin
            o_cmd.two  = 1'b0;
            o_cmd.res0 = '{n_pqb, n_pqf, n_ptb, n_ptf, 1'b1};
            o_cmd.res1 = '{n_pqb, n_pqf, n_ptb, n_ptf, 1'b1};
        end
    end

    assign o_push = accept && (emit_old || i_item.list_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (accept) begin
            r_pv <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pqb <= n_pqb;
            r_pqf <= n_pqf;
            r_ptb <= n_ptb;
            r_ptf <= n_ptf;
        end
    end

endmodule

[hw/rtl/nom_queue.sv]
// Short command queue between front and back.
module nom_queue import nom_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_stat
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

endmodule

[hw/rtl/nom_back.sv]
// Back end: delivers the one or two result items of each queued command.
module nom_back import nom_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_head,
    input  t_q_status i_qstat,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);

    logic r_sub;
    logic accept;

    assign o_valid = !i_qstat.empty;
    assign o_item  = r_sub ? i_head.res1 : i_head.res0;
    assign accept  = o_valid && !i_stall;
    assign o_pop   = accept && (r_sub || !i_head.two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 1'b0;
        end else if (accept) begin
            r_sub <= !o_pop;
        end
    end

endmodule

[hw/rtl/needle_overlap_merge.sv]
// Top level of the needle overlap merge block.
// Cleans up a stream of alignment blocks sorted by query start. One block is
// held pending; each new item is compared with it at acceptance and is
// dropped, trimmed, merged or started fresh, and an item with list_end set
// flushes the pending block marked final. The front end does the compare and
// pending-register update together, so an input item can be taken every
// cycle while the queue is not full. Results go through a 4-entry command
// queue to the back end, which drives the output port one result item per
// cycle when not stalled; an input item that causes two results holds the
// output until both are taken. Sustained rate is one item per cycle while
// each item causes at most one result and the output is not stalled, else
// set by the single output port. Input stall rises only on a full queue.
module needle_overlap_merge import nom_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    t_q_status qstat;
    t_cmd      push_cmd;
    t_cmd      head;
    logic      push;
    logic      pop;

    // classify and update the pending block
    nom_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_stall (o_in_stall),
        .i_qstat (qstat),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // decouples the compare stage from output back-pressure
    nom_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    // serialize one or two results per command
    nom_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .i_stall (i_out_stall)
    );

endmodule

[hw/rtl/nom_checker.sv]
// Port-level checker for the needle overlap merge block, with its bind.
module nom_checker import nom_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input t_in_item  i_in_item,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_item o_out_item,
    input logic      i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output item changed");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result waiting");

    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_item.list_end && !o_out_valid |=> o_out_valid)
        else $error("end of list gave no result item");

endmodule

bind needle_overlap_merge nom_checker u_nom_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_item   (i_in_item),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);

[tb/sv/needle_overlap_merge_tb.sv]
// Self-checking testbench for the needle overlap merge block: directed lists, then random streams.
module needle_overlap_merge_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nom_pkg::*;

    localparam int RST_CYCLES   = 12;
    localparam int STALL_LIMIT  = 4000;  // cycles with no item moving on either side
    localparam int TAIL_CYCLES  = 8;     // queue depth plus output latency, with margin
    localparam int ITEMS_PHASE  = 460;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_item  i_in_item;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;
    logic      i_out_stall = 1'b0;

    // Idle percentages for sender and receiver, set per phase.
    int in_idle_pct  = 29;
    int out_idle_pct = 87;

    int n_err       = 0;
    int items_sent  = 0;
    int quiet_count = 0;

    // Predicted pending block and the results still owed by the block.
    logic        pend_valid = 1'b0;
    logic [31:0] pend_qb    = '0;
    logic [31:0] pend_qf    = '0;
    logic [31:0] pend_tb    = '0;
    logic [31:0] pend_tf    = '0;
    t_out_item   expected_blocks[$];

    needle_overlap_merge u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic t_out_item pending_result(input logic fin);
        t_out_item r;
        r.out_query_begin   = pend_qb;
        r.out_query_finish  = pend_qf;
        r.out_target_begin  = pend_tb;
        r.out_target_finish = pend_tf;
        r.out_final         = fin;
        return r;
    endfunction

    task automatic take_pending(input logic [31:0] qb, qf, tb, tf);
        pend_valid = 1'b1;
        pend_qb    = qb;
        pend_qf    = qf;
        pend_tb    = tb;
        pend_tf    = tf;
    endtask

    task automatic predict_merge(input t_in_item it);
        logic [31:0] overlap;
        if (!pend_valid) begin
            take_pending(it.query_begin, it.query_finish, it.target_begin, it.target_finish);
        end else if (pend_qf > it.query_begin) begin
            // covered blocks are dropped; otherwise trim the new block's head
            if (!(pend_qb <= it.query_begin && pend_qf >= it.query_finish)) begin
                overlap = pend_qf - it.query_begin;
                expected_blocks.push_back(pending_result(1'b0));
                take_pending(pend_qf, it.query_finish, it.target_begin + overlap,
                             it.target_finish);
            end
        end else if (pend_qf == it.query_begin && pend_tf == it.target_begin) begin
            pend_qf = it.query_finish;
            pend_tf = it.target_finish;
        end else begin
            expected_blocks.push_back(pending_result(1'b0));
            take_pending(it.query_begin, it.query_finish, it.target_begin, it.target_finish);
        end
        if (it.list_end) begin
            expected_blocks.push_back(pending_result(1'b1));
            pend_valid = 1'b0;
            pend_qb    = '0;
            pend_qf    = '0;
            pend_tb    = '0;
            pend_tf    = '0;
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        want = expected_blocks.pop_front();
        if (got.out_query_begin !== want.out_query_begin) begin
            $error("out_query_begin: expected %h, actual %h",
                   want.out_query_begin, got.out_query_begin);
            n_err++;
        end
        if (got.out_query_finish !== want.out_query_finish) begin
            $error("out_query_finish: expected %h, actual %h",
                   want.out_query_finish, got.out_query_finish);
            n_err++;
        end
        if (got.out_target_begin !== want.out_target_begin) begin
            $error("out_target_begin: expected %h, actual %h",
                   want.out_target_begin, got.out_target_begin);
            n_err++;
        end
        if (got.out_target_finish !== want.out_target_finish) begin
            $error("out_target_finish: expected %h, actual %h",
                   want.out_target_finish, got.out_target_finish);
            n_err++;
        end
        if (got.out_final !== want.out_final) begin
            $error("out_final: expected %b, actual %b", want.out_final, got.out_final);
            n_err++;
        end
    endtask

    // Prediction and checking share one process, so their order within an edge is fixed.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_merge(i_in_item);
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_blocks.size() == 0) begin
                    $error("unexpected result item: qb %h qf %h tb %h tf %h final %b",
                           o_out_item.out_query_begin, o_out_item.out_query_finish,
                           o_out_item.out_target_begin, o_out_item.out_target_finish,
                           o_out_item.out_final);
                    n_err++;
                end else begin
                    check_result(o_out_item);
                end
            end
        end
    end

    // Receiver backpressure.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    // Watchdog: no item moving on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_count = 0;
        end else begin
            quiet_count++;
        end
        if (quiet_count >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic t_in_item mk_block(input logic [31:0] qb, qf, tb, tf,
                                          input logic tail);
        t_in_item it;
        it.query_begin   = qb;
        it.query_finish  = qf;
        it.target_begin  = tb;
        it.target_finish = tf;
        it.list_end      = tail;
        return it;
    endfunction

    // Drives one item and returns after the edge that accepted it; valid stays high.
    task automatic send_block(input t_in_item it);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_blocks.size() != 0);
    endtask

    function automatic logic [31:0] pick_base();
        case ($urandom_range(3))
            0:       return $urandom_range(0, 1000);
            1:       return 32'hFFFF_F000 + $urandom_range(0, 4095);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_len();
        if ($urandom_range(9) == 0) return $urandom_range(0, 4000);
        return $urandom_range(0, 64);
    endfunction

    task automatic test_single_blocks();
        send_block(mk_block(32'h0, 32'h0, 32'h0, 32'h0, 1'b1));
        send_block(mk_block('1, '1, '1, '1, 1'b1));
        // empty block followed by an inverted one
        send_block(mk_block(32'd50, 32'd50, 32'd70, 32'd70, 1'b0));
        send_block(mk_block(32'd90, 32'd60, 32'd95, 32'd80, 1'b1));
    endtask

    task automatic test_covered_drop();
        send_block(mk_block(32'd100, 32'd200, 32'd1000, 32'd1100, 1'b0));
        send_block(mk_block(32'd120, 32'd180, 32'd5, 32'd6, 1'b0));
        send_block(mk_block(32'd100, 32'd200, 32'd7, 32'd8, 1'b1));
    endtask

    task automatic test_overlap_trim();
        send_block(mk_block(32'd100, 32'd200, 32'd1000, 32'd1100, 1'b0));
        send_block(mk_block(32'd150, 32'd300, 32'd2000, 32'd2150, 1'b1));
        // target start wraps after the trim
        send_block(mk_block(32'h0000_0000, 32'h8000_0000, 32'h0, 32'h10, 1'b0));
        send_block(mk_block(32'h0000_0010, 32'h9000_0000, 32'hFFFF_FFF0, 32'h5, 1'b1));
    endtask

    task automatic test_abut_merge();
        send_block(mk_block(32'd100, 32'd200, 32'd1000, 32'd1100, 1'b0));
        send_block(mk_block(32'd150, 32'd300, 32'd2000, 32'd2150, 1'b0));
        send_block(mk_block(32'd300, 32'd400, 32'd2150, 32'd2250, 1'b0));
        send_block(mk_block(32'd400, 32'd410, 32'd2250, 32'd2260, 1'b1));
    endtask

    task automatic test_gap_emit();
        send_block(mk_block(32'd10, 32'd20, 32'd30, 32'd40, 1'b0));
        send_block(mk_block(32'd30, 32'd40, 32'd50, 32'd60, 1'b0));
        // query abuts but target does not
        send_block(mk_block(32'd40, 32'd50, 32'd61, 32'd70, 1'b1));
    endtask

    task automatic test_unsorted_inverted();
        send_block(mk_block(32'd500, 32'd600, 32'd5000, 32'd5100, 1'b0));
        send_block(mk_block(32'd100, 32'd700, 32'd9000, 32'd9600, 1'b0));
        // trimmed start lands above the new finish
        send_block(mk_block(32'd300, 32'd50, 32'd10, 32'd20, 1'b1));
    endtask

    // One sorted list, each block picked at random to hit merge, trim, drop or gap cases.
    task automatic send_sorted_list();
        int          n_blocks;
        logic [31:0] lqb, lqf, ltb, ltf;
        logic [31:0] qb, qf, tb, tf, span, room;
        n_blocks = $urandom_range(1, 12);
        lqb = pick_base();
        lqf = lqb + pick_len();
        ltb = pick_base();
        ltf = ltb + (lqf - lqb);
        send_block(mk_block(lqb, lqf, ltb, ltf, n_blocks == 1));
        for (int k = 1; k < n_blocks; k++) begin
            span = lqf - lqb;
            case ($urandom_range(9))
                0, 1, 2: begin                 // exact abut on both axes
                    qb = lqf;
                    tb = ltf;
                    qf = qb + pick_len();
                    tf = tb + (qf - qb);
                end
                3, 4: begin                    // clear gap
                    qb = lqf + $urandom_range(1, 60);
                    tb = ltf + $urandom_range(0, 60);
                    qf = qb + pick_len();
                    tf = tb + (qf - qb);
                end
                5, 6: begin                    // partial overlap
                    qb = lqb + ((span == 0) ? 32'd0 : $urandom % span);
                    qf = lqf + $urandom_range(1, 40);
                    tb = ltb + (qb - lqb);
                    tf = tb + (qf - qb);
                end
                7: begin                       // inside the previous block
                    qb = lqb + ((span == 0) ? 32'd0 : $urandom % span);
                    room = lqf - qb;
                    qf = qb + ((room == 0) ? 32'd0 : $urandom % room);
                    tb = $urandom;
                    tf = tb + (qf - qb);
                end
                8: begin                       // same start, random finish
                    qb = lqb;
                    qf = qb + pick_len();
                    tb = ltb;
                    tf = tb + (qf - qb);
                end
                default: begin                 // query abuts, target off
                    qb = lqf;
                    tb = ltf + $urandom_range(1, 20);
                    qf = qb + pick_len();
                    tf = tb + (qf - qb);
                end
            endcase
            send_block(mk_block(qb, qf, tb, tf, k == n_blocks - 1));
            lqb = qb;
            lqf = qf;
            ltb = tb;
            ltf = tf;
        end
    endtask

    task automatic send_noise();
        int n_noise;
        n_noise = $urandom_range(1, 4);
        repeat (n_noise) begin
            send_block(mk_block($urandom, $urandom, $urandom, $urandom,
                                $urandom_range(7) == 0));
        end
    endtask

    task automatic test_random_stream(input int n_items, input int in_pct, input int out_pct);
        int start_count;
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        start_count  = items_sent;
        while (items_sent - start_count < n_items) begin
            if ($urandom_range(99) < 80) begin
                send_sorted_list();
            end else begin
                send_noise();
            end
        end
    endtask

    // Sender holds off mid-list until every owed result is out, then resumes.
    task automatic test_drain_pause();
        send_block(mk_block(32'd1000, 32'd1100, 32'd10, 32'd110, 1'b0));
        send_block(mk_block(32'd1200, 32'd1300, 32'd300, 32'd400, 1'b0));
        hold_until_drained();
        send_block(mk_block(32'd1300, 32'd1350, 32'd400, 32'd450, 1'b1));
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_blocks();
        test_covered_drop();
        test_overlap_trim();
        test_abut_merge();
        test_gap_emit();
        test_unsorted_inverted();
        test_drain_pause();

        test_random_stream(ITEMS_PHASE, 29, 87);
        test_drain_pause();
        test_random_stream(ITEMS_PHASE, 87, 29);
        test_random_stream(ITEMS_PHASE, 0, 0);

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_blocks.size() != 0) begin
            $error("%0d expected result items never arrived", expected_blocks.size());
            n_err++;
        end
        if (n_err == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
